>>> hw/rtl/subr_pkg.sv
// ----------------------------------------------------------------------------
// subr_pkg
// Types, codes and opcode constants of the branch/return stepping unit.
// ----------------------------------------------------------------------------
package subr_pkg;

	localparam int DEPTH_BITS_DEF = 16;
	localparam int DEPTH_OUT_W    = 16;

	typedef enum logic [1:0] {
		CMD_STEP       = 2'd0,
		CMD_ARM_BRANCH = 2'd1,
		CMD_ARM_RETURN = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		MODE_NONE   = 2'd0,
		MODE_BRANCH = 2'd1,
		MODE_RETURN = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		REASON_NONE = 2'd0,
		REASON_STEP = 2'd1,
		REASON_COND = 2'd2
	} reason_t;

	localparam logic [7:0] OP_ESC      = 8'h0f;
	localparam logic [7:0] OP_GRP5     = 8'hff;
	localparam logic [7:0] RET_MASK    = 8'hf6;
	localparam logic [7:0] RET_CODE    = 8'hc2;
	localparam logic [7:0] OP_IRET     = 8'hcf;
	localparam logic [7:0] OP_CALL     = 8'he8;
	localparam logic [7:0] OP_CALLF    = 8'h9a;
	localparam logic [7:0] LOOP_MASK   = 8'hfc;
	localparam logic [7:0] LOOP_CODE   = 8'he0;
	localparam logic [7:0] JCC_MASK    = 8'hf0;
	localparam logic [7:0] JCC_CODE    = 8'h70;
	localparam logic [7:0] OP_JMPS     = 8'heb;
	localparam logic [7:0] OP_JMP      = 8'he9;
	localparam logic [7:0] OP_JMPF     = 8'hea;
	localparam logic [7:0] JCC2_CODE   = 8'h80;
	localparam logic [7:0] MODRM_MASK  = 8'h30;
	localparam logic [7:0] MODRM_CALL  = 8'h10;
	localparam logic [7:0] MODRM_JMP   = 8'h20;
	localparam logic [7:0] OP_INT3     = 8'hcc;
	localparam logic [7:0] OP_INT      = 8'hcd;
	localparam logic [7:0] OP_INTO     = 8'hce;

	typedef struct packed {
		logic call;
		logic ret;
		logic branch;
		logic intr;
	} class_t;

	function automatic class_t classify(input logic [7:0] b1, input logic [7:0] b2_raw);
		logic [7:0] b2;
		class_t     c;
		b2 = (b1 == OP_ESC || b1 == OP_GRP5) ? b2_raw : 8'h00;
		c.ret    = ((b1 & RET_MASK) == RET_CODE) || (b1 == OP_IRET);
		c.call   = (b1 == OP_CALL) || (b1 == OP_CALLF)
		        || (b1 == OP_GRP5 && (b2 & MODRM_MASK) == MODRM_CALL);
		c.branch = ((b1 & LOOP_MASK) == LOOP_CODE) || ((b1 & JCC_MASK) == JCC_CODE)
		        || (b1 == OP_JMPS) || (b1 == OP_JMP) || (b1 == OP_JMPF)
		        || (b1 == OP_ESC && (b2 & JCC_MASK) == JCC2_CODE)
		        || (b1 == OP_GRP5 && (b2 & MODRM_MASK) == MODRM_JMP);
		c.intr   = (b1 == OP_INT3) || (b1 == OP_INT) || (b1 == OP_INTO);
		return c;
	endfunction

endpackage

>>> hw/rtl/subr_if.sv
// ----------------------------------------------------------------------------
// subr_if
// Valid/ready channels of the stepping unit: trap/command in, decision out.
// ----------------------------------------------------------------------------
interface subr_req_if import subr_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] opcode_first;
	logic [7:0] opcode_second;
	logic       opcode_valid;

	modport source (output valid, cmd, opcode_first, opcode_second, opcode_valid,
		input ready);
	modport sink (input valid, cmd, opcode_first, opcode_second, opcode_valid,
		output ready);
endinterface

interface subr_rsp_if import subr_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   stop;
	logic [1:0]             reason;
	logic                   is_call;
	logic                   is_return;
	logic                   is_branch;
	logic                   is_interrupt;
	logic [DEPTH_OUT_W-1:0] depth_out;

	modport source (output valid, stop, reason, is_call, is_return, is_branch,
		is_interrupt, depth_out, input ready);
	modport sink (input valid, stop, reason, is_call, is_return, is_branch,
		is_interrupt, depth_out, output ready);
endinterface

>>> hw/rtl/step_until_branch_or_return.sv
// ----------------------------------------------------------------------------
// step_until_branch_or_return
// Classifies the instruction at each trap and decides whether the debugger
// stops in go-until-branch or go-until-return stepping.
//
// Usage:
//   req carries one command per transfer: a single-step trap or an arm
//   command, with the first two opcode bytes at the current IP. rsp returns
//   exactly one decision per request: stop, reason, the instruction classes
//   and the call depth (low 16 bits).
//   A req item passes through the input register, then through the decode
//   and depth update into the result register.
//   Throughput is one transfer per cycle while rsp is not stalled; the mode and
//   depth registers are updated as each item moves into the result register,
//   so the next item sees them at once.
//   When rsp is stalled the input register holds one more item; req.ready
//   drops only when both registers are full.
//   cfg_we writes branch_trap_hw from cfg_wdata; write it only while idle.
//   Reset empties both registers and clears the mode, the depth and classes.
// ----------------------------------------------------------------------------
module step_until_branch_or_return import subr_pkg::*; #(
	parameter int DEPTH_BITS = DEPTH_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	subr_req_if.sink   req,
	subr_rsp_if.source rsp
);

	localparam int EXT_W = (DEPTH_BITS > DEPTH_OUT_W) ? DEPTH_BITS : DEPTH_OUT_W;

	logic                  bt_hw_q;
	mode_t                 mode_q, mode_n;
	logic [DEPTH_BITS-1:0] depth_q, depth_n;
	class_t                class_q, class_n;

	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [7:0] op1_s1, op2_s1;
	logic       opv_s1;

	logic       rsp_valid_s2;
	logic       advance;
	logic       stop_c;
	reason_t    reason_c;
	logic [EXT_W-1:0] depth_ext;

	assign advance   = valid_s1 && (!rsp_valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bt_hw_q <= 1'b0;
		end else if (cfg_we) begin
			bt_hw_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= req.cmd;
			op1_s1 <= req.opcode_first;
			op2_s1 <= req.opcode_second;
			opv_s1 <= req.opcode_valid;
		end
	end

	always_comb begin
		class_n  = opv_s1 ? classify(op1_s1, op2_s1) : class_q;
		mode_n   = mode_q;
		depth_n  = depth_q;
		stop_c   = 1'b0;
		reason_c = REASON_NONE;
		unique case (cmd_s1)
			CMD_ARM_BRANCH, CMD_ARM_RETURN: begin
				depth_n = class_n.call ? DEPTH_BITS'(1) : '0;
				mode_n  = (cmd_s1 == CMD_ARM_BRANCH) ? MODE_BRANCH : MODE_RETURN;
			end
			CMD_STEP: begin
				if (mode_q == MODE_NONE) begin
					stop_c   = 1'b1;
					reason_c = REASON_STEP;
				end else begin
					if (bt_hw_q) begin
						stop_c = 1'b1;
					end else if (mode_q == MODE_RETURN) begin
						if (class_n.call) begin
							if (depth_q != '1)
								depth_n = depth_q + DEPTH_BITS'(1);
						end else if (class_n.ret) begin
							if (depth_q == '0)
								stop_c = 1'b1;
							else
								depth_n = depth_q - DEPTH_BITS'(1);
						end
					end else begin
						stop_c = class_n.call | class_n.ret | class_n.branch | class_n.intr;
					end
					if (stop_c) begin
						mode_n   = MODE_NONE;
						reason_c = REASON_COND;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NONE;
			depth_q <= '0;
			class_q <= '0;
		end else if (advance) begin
			mode_q  <= mode_n;
			depth_q <= depth_n;
			class_q <= class_n;
		end
	end

	assign depth_ext = EXT_W'(depth_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_s2 <= 1'b0;
		end else if (!rsp_valid_s2 || rsp.ready) begin
			rsp_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp.stop         <= stop_c;
			rsp.reason       <= reason_c;
			rsp.is_call      <= class_n.call;
			rsp.is_return    <= class_n.ret;
			rsp.is_branch    <= class_n.branch;
			rsp.is_interrupt <= class_n.intr;
			rsp.depth_out    <= depth_ext[DEPTH_OUT_W-1:0];
		end
	end

	assign rsp.valid = rsp_valid_s2;

`ifndef ASSERT_OFF
	a_stop_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.stop |-> rsp.reason != REASON_NONE)
		else $error("stop without reason");

	a_stop_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		advance && stop_c |=> mode_q == MODE_NONE)
		else $error("mode still armed after stop");

	a_arm_depth: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (cmd_s1 == CMD_ARM_BRANCH || cmd_s1 == CMD_ARM_RETURN)
		|=> depth_q == (class_q.call ? DEPTH_BITS'(1) : '0))
		else $error("arm depth wrong");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> req.ready)
		else $error("input stalled with empty stage");

	a_no_stop_armed_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd_s1 == CMD_STEP && mode_q != MODE_NONE && !stop_c
		|=> mode_q == $past(mode_q))
		else $error("mode changed without stop");
`endif

endmodule

>>> tb/step_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// step_tb_pkg
// Request items, opcode generators and the stop-decision predictor used by
// the testbench of the branch/return stepping unit.
// ----------------------------------------------------------------------------
package step_tb_pkg;
	import subr_pkg::*;

	localparam int DW = DEPTH_BITS_DEF;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [7:0] OPC_TWO_BYTE = 8'h0f;
	localparam logic [7:0] OPC_GRP5     = 8'hff;
	localparam logic [7:0] OPC_RET_IMM  = 8'hc2;
	localparam logic [7:0] OPC_RET      = 8'hc3;
	localparam logic [7:0] OPC_LRET_IMM = 8'hca;
	localparam logic [7:0] OPC_LRET     = 8'hcb;
	localparam logic [7:0] OPC_IRET     = 8'hcf;
	localparam logic [7:0] OPC_CALL     = 8'he8;
	localparam logic [7:0] OPC_CALLF    = 8'h9a;
	localparam logic [7:0] OPC_LOOP_LO  = 8'he0;
	localparam logic [7:0] OPC_LOOP_HI  = 8'he3;
	localparam logic [7:0] OPC_JCC_LO   = 8'h70;
	localparam logic [7:0] OPC_JCC_HI   = 8'h7f;
	localparam logic [7:0] OPC_JCC2_LO  = 8'h80;
	localparam logic [7:0] OPC_JCC2_HI  = 8'h8f;
	localparam logic [7:0] OPC_JMPS     = 8'heb;
	localparam logic [7:0] OPC_JMP_REL  = 8'he9;
	localparam logic [7:0] OPC_JMPF     = 8'hea;
	localparam logic [7:0] OPC_INT3     = 8'hcc;
	localparam logic [7:0] OPC_INT      = 8'hcd;
	localparam logic [7:0] OPC_INTO     = 8'hce;
	localparam logic [7:0] OPC_NOP      = 8'h90;
	localparam logic [7:0] OPC_MOV      = 8'h8b;
	localparam logic [1:0] GRP5_CALL    = 2'b01;
	localparam logic [1:0] GRP5_JMP     = 2'b10;

	localparam int KIND_CALL  = 0;
	localparam int KIND_RET   = 1;
	localparam int KIND_BR    = 2;
	localparam int KIND_INTR  = 3;
	localparam int KIND_ANY   = 4;
	localparam int KIND_PLAIN = 5;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] opcode_first;
		logic [7:0] opcode_second;
		logic       opcode_valid;
	} req_item_t;

	typedef struct packed {
		logic                   stop;
		logic [1:0]             reason;
		logic                   is_call;
		logic                   is_return;
		logic                   is_branch;
		logic                   is_interrupt;
		logic [DEPTH_OUT_W-1:0] depth_out;
	} decision_t;

	function automatic req_item_t mk(logic [1:0] c, logic [7:0] a, logic [7:0] b, logic v);
		req_item_t it;
		it.cmd           = c;
		it.opcode_first  = a;
		it.opcode_second = b;
		it.opcode_valid  = v;
		return it;
	endfunction

	function automatic req_item_t rand_item(logic [1:0] c, int kind);
		logic [7:0] a;
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		case (kind)
			KIND_CALL: begin
				case ($urandom_range(0, 2))
					0: a = OPC_CALL;
					1: a = OPC_CALLF;
					default: begin
						a = OPC_GRP5;
						b[5:4] = GRP5_CALL;
					end
				endcase
			end
			KIND_RET: begin
				case ($urandom_range(0, 4))
					0: a = OPC_RET_IMM;
					1: a = OPC_RET;
					2: a = OPC_LRET_IMM;
					3: a = OPC_LRET;
					default: a = OPC_IRET;
				endcase
			end
			KIND_BR: begin
				case ($urandom_range(0, 6))
					0: a = OPC_LOOP_LO + 8'($urandom_range(0, 3));
					1: a = OPC_JCC_LO + 8'($urandom_range(0, 15));
					2: a = OPC_JMPS;
					3: a = OPC_JMP_REL;
					4: a = OPC_JMPF;
					5: begin
						a = OPC_TWO_BYTE;
						b = OPC_JCC2_LO + 8'($urandom_range(0, 15));
					end
					default: begin
						a = OPC_GRP5;
						b[5:4] = GRP5_JMP;
					end
				endcase
			end
			KIND_INTR: a = OPC_INT3 + 8'($urandom_range(0, 2));
			KIND_PLAIN: begin
				case ($urandom_range(0, 2))
					0: a = OPC_NOP;
					1: a = OPC_MOV;
					default: begin
						a = OPC_TWO_BYTE;
						b[7] = 1'b0;
					end
				endcase
			end
			default: a = 8'($urandom_range(0, 255));
		endcase
		return mk(c, a, b, $urandom_range(0, 9) != 0);
	endfunction

	class stop_predictor;
		bit          trap_hw;
		mode_t       mode;
		logic [DW-1:0] depth;
		logic        c_call, c_ret, c_br, c_int;
		decision_t   pending_decisions[$];
		int          errors;

		function new();
			trap_hw = 0;
			mode    = MODE_NONE;
			depth   = '0;
			c_call  = 0;
			c_ret   = 0;
			c_br    = 0;
			c_int   = 0;
			errors  = 0;
		endfunction

		function void set_trap_hw(bit v);
			trap_hw = v;
		endfunction

		function int pending();
			return pending_decisions.size();
		endfunction

		function void note_request(req_item_t it);
			decision_t  d;
			logic [7:0] a;
			logic [7:0] b;
			logic       brk;
			d   = '0;
			brk = 0;
			a   = it.opcode_first;
			b   = (a == OPC_TWO_BYTE || a == OPC_GRP5) ? it.opcode_second : 8'h00;
			if (it.opcode_valid) begin
				c_ret  = a inside {OPC_RET_IMM, OPC_RET, OPC_LRET_IMM, OPC_LRET, OPC_IRET};
				c_call = a == OPC_CALL || a == OPC_CALLF
					|| (a == OPC_GRP5 && b[5:4] == GRP5_CALL);
				c_br   = a inside {[OPC_LOOP_LO:OPC_LOOP_HI], [OPC_JCC_LO:OPC_JCC_HI],
						OPC_JMPS, OPC_JMP_REL, OPC_JMPF}
					|| (a == OPC_TWO_BYTE && b inside {[OPC_JCC2_LO:OPC_JCC2_HI]})
					|| (a == OPC_GRP5 && b[5:4] == GRP5_JMP);
				c_int  = a inside {OPC_INT3, OPC_INT, OPC_INTO};
			end
			case (it.cmd)
				CMD_ARM_BRANCH, CMD_ARM_RETURN: begin
					depth = c_call ? DW'(1) : '0;
					mode  = (it.cmd == CMD_ARM_BRANCH) ? MODE_BRANCH : MODE_RETURN;
				end
				CMD_STEP: begin
					if (mode == MODE_NONE) begin
						d.stop   = 1;
						d.reason = REASON_STEP;
					end else begin
						if (trap_hw) begin
							brk = 1;
						end else if (mode == MODE_RETURN) begin
							if (c_call) begin
								if (depth != '1)
									depth = depth + 1'b1;
							end else if (c_ret) begin
								if (depth == '0)
									brk = 1;
								else
									depth = depth - 1'b1;
							end
						end else begin
							brk = c_call | c_ret | c_br | c_int;
						end
						if (brk) begin
							mode     = MODE_NONE;
							d.stop   = 1;
							d.reason = REASON_COND;
						end
					end
				end
				default: ;
			endcase
			d.is_call      = c_call;
			d.is_return    = c_ret;
			d.is_branch    = c_br;
			d.is_interrupt = c_int;
			d.depth_out    = DEPTH_OUT_W'(depth);
			pending_decisions.push_back(d);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 30)
				$display("%0t mismatch: %s", $time, msg);
		endtask

		task check_decision(logic stop, logic [1:0] reason, logic is_call, logic is_return,
				logic is_branch, logic is_interrupt, logic [DEPTH_OUT_W-1:0] depth_out);
			decision_t e;
			if (pending_decisions.size() == 0) begin
				report("result transfer with no request pending");
				return;
			end
			e = pending_decisions.pop_front();
			if (stop !== e.stop)
				report($sformatf("stop got %b exp %b", stop, e.stop));
			if (reason !== e.reason)
				report($sformatf("reason got %0d exp %0d", reason, e.reason));
			if (is_call !== e.is_call)
				report($sformatf("is_call got %b exp %b", is_call, e.is_call));
			if (is_return !== e.is_return)
				report($sformatf("is_return got %b exp %b", is_return, e.is_return));
			if (is_branch !== e.is_branch)
				report($sformatf("is_branch got %b exp %b", is_branch, e.is_branch));
			if (is_interrupt !== e.is_interrupt)
				report($sformatf("is_interrupt got %b exp %b", is_interrupt, e.is_interrupt));
			if (depth_out !== e.depth_out)
				report($sformatf("depth_out got %0d exp %0d", depth_out, e.depth_out));
		endtask
	endclass

endpackage

>>> tb/tb_step_until_branch_or_return.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_step_until_branch_or_return
// Drives traps and arm commands into the stepping unit with bursty input and
// a stalling receiver, predicts every decision and checks it field by field.
// Covers both trap-hardware settings and nested call/return depth tracking.
// ----------------------------------------------------------------------------
module tb_step_until_branch_or_return;
	import subr_pkg::*;
	import step_tb_pkg::*;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	subr_req_if req_ch ();
	subr_rsp_if rsp_ch ();

	step_until_branch_or_return dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	stop_predictor sb;
	bit rx_free  = 0;
	bit hold_req = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("tb_step_until_branch_or_return: FAIL");
		$finish;
	end

	// the receiver switches among random stall patterns and stalls outright on hold_req
	initial begin
		int rx_mode;
		int rx_left;
		int hold_left;
		int phase;
		rx_mode   = 0;
		rx_left   = 0;
		hold_left = 0;
		phase     = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 0;
				hold_left = 120;
			end
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_left = $urandom_range(30, 150);
			end
			rx_left--;
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rx_free) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				case (rx_mode)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= 1'($urandom_range(0, 1));
					2: rsp_ch.ready <= (phase % 4) == 0;
					default: rsp_ch.ready <= $urandom_range(0, 7) == 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_decision(rsp_ch.stop, rsp_ch.reason, rsp_ch.is_call, rsp_ch.is_return,
				rsp_ch.is_branch, rsp_ch.is_interrupt, rsp_ch.depth_out);
	end

	task automatic send_all(ref req_item_t q[$], input bit no_gaps);
		int idx;
		int burst;
		int gap;
		idx = 0;
		while (idx < q.size()) begin
			burst = $urandom_range(1, 32);
			for (int k = 0; k < burst && idx < q.size(); k++) begin
				@(negedge clk);
				req_ch.valid         <= 1'b1;
				req_ch.cmd           <= q[idx].cmd;
				req_ch.opcode_first  <= q[idx].opcode_first;
				req_ch.opcode_second <= q[idx].opcode_second;
				req_ch.opcode_valid  <= q[idx].opcode_valid;
				@(posedge clk);
				while (!req_ch.ready)
					@(posedge clk);
				sb.note_request(q[idx]);
				idx++;
			end
			gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				req_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		req_ch.valid <= 1'b0;
	endtask

	task automatic write_trap_hw(bit v);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
		sb.set_trap_hw(v);
	endtask

	initial begin
		req_item_t  q[$];
		logic [1:0] arm;
		int         kind;
		int         r;
		int         len;
		bit         trap_seq[4];
		trap_seq = '{1'b0, 1'b1, 1'b0, 1'b1};
		arst_n               <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.cmd           <= CMD_STEP;
		req_ch.opcode_first  <= 8'h00;
		req_ch.opcode_second <= 8'h00;
		req_ch.opcode_valid  <= 1'b0;
		sb = new();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		write_trap_hw(1'b0);
		q.push_back(mk(CMD_STEP, 8'h00, 8'h00, 1'b0));
		q.push_back(mk(CMD_STEP, 8'hff, 8'hff, 1'b1));
		q.push_back(mk(CMD_UNUSED, OPC_INT3, 8'h00, 1'b1));
		q.push_back(mk(CMD_ARM_RETURN, OPC_CALL, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_GRP5, 8'hd0, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_RET, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_CALLF, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_GRP5, 8'h25, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_RET_IMM, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_LRET_IMM, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_LRET, 8'h00, 1'b1));
		q.push_back(mk(CMD_ARM_BRANCH, OPC_TWO_BYTE, 8'h85, 1'b1));
		q.push_back(mk(CMD_STEP, 8'h00, 8'h00, 1'b0));
		q.push_back(mk(CMD_ARM_BRANCH, OPC_NOP, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_TWO_BYTE, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_LOOP_HI, 8'h00, 1'b1));
		q.push_back(mk(CMD_ARM_RETURN, OPC_NOP, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_INTO, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_IRET, 8'h00, 1'b1));
		q.push_back(mk(CMD_ARM_BRANCH, OPC_NOP, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_INT, 8'hff, 1'b1));
		send_all(q, 1'b0);
		q.delete();

		write_trap_hw(1'b1);
		q.push_back(mk(CMD_ARM_RETURN, OPC_NOP, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_NOP, 8'h00, 1'b1));
		q.push_back(mk(CMD_STEP, OPC_NOP, 8'h00, 1'b1));
		send_all(q, 1'b0);
		q.delete();

		// nested calls, then returns down to depth zero and one more, which stops
		write_trap_hw(1'b0);
		rx_free = 1;
		q.push_back(mk(CMD_ARM_RETURN, OPC_CALL, 8'h00, 1'b1));
		repeat (12) q.push_back(mk(CMD_STEP, OPC_CALL, 8'h00, 1'b1));
		repeat (14) q.push_back(mk(CMD_STEP, OPC_RET, 8'h00, 1'b1));
		send_all(q, 1'b1);
		q.delete();
		while (sb.pending() != 0)
			@(posedge clk);
		rx_free = 0;

		for (int p = 0; p < 4; p++) begin
			write_trap_hw(trap_seq[p]);
			while (q.size() < 285) begin
				if ($urandom_range(0, 9) < 7) begin
					arm = $urandom_range(0, 1) ? CMD_ARM_RETURN : CMD_ARM_BRANCH;
					q.push_back(rand_item(arm, $urandom_range(0, 5)));
					len = $urandom_range(1, 24);
					repeat (len) begin
						r = $urandom_range(0, 9);
						if (arm == CMD_ARM_RETURN)
							kind = (r < 3) ? KIND_CALL : (r < 6) ? KIND_RET : (r == 6) ? KIND_BR
								: (r == 7) ? KIND_INTR : (r == 8) ? KIND_ANY : KIND_PLAIN;
						else
							kind = (r < 6) ? KIND_PLAIN : (r < 8) ? KIND_ANY : (r == 8) ? KIND_BR
								: $urandom_range(0, 3);
						q.push_back(rand_item(CMD_STEP, kind));
					end
				end else begin
					repeat ($urandom_range(1, 5))
						q.push_back(rand_item(2'($urandom_range(0, 3)), $urandom_range(0, 5)));
				end
			end
			if (p == 1)
				hold_req = 1;
			send_all(q, p == 1);
			q.delete();
		end

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_step_until_branch_or_return: PASS");
		else
			$display("tb_step_until_branch_or_return: FAIL");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/subr_pkg.sv
hw/rtl/subr_if.sv
hw/rtl/step_until_branch_or_return.sv
tb/step_tb_pkg.sv
tb/tb_step_until_branch_or_return.sv
